FILE: hw/rtl/stz_pkg.sv
package stz_pkg;

  localparam int TBL_DEPTH = 256;
  localparam int TBL_AW = $clog2(TBL_DEPTH);
  localparam int CORDIC_STEPS = 18;
  localparam int IW = 5;
  localparam int CW = 30;
  localparam int ZW = 23;
  localparam logic signed [16:0] PI_Q12 = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_MIN_SPEED = 2'd1;
  localparam logic [1:0] REG_RATE = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic accept;
    logic ld_dpsi;
    logic wrap;
    logic step;
    logic [IW-1:0] iter;
    logic round;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic tick_ok;
    logic dpsi_ok;
    logic out_full;
  } sts_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0: r = 23'sd823550;
      5'd1: r = 23'sd486170;
      5'd2: r = 23'sd256879;
      5'd3: r = 23'sd130396;
      5'd4: r = 23'sd65451;
      5'd5: r = 23'sd32757;
      5'd6: r = 23'sd16383;
      5'd7: r = 23'sd8192;
      5'd8: r = 23'sd4096;
      5'd9: r = 23'sd2048;
      5'd10: r = 23'sd1024;
      5'd11: r = 23'sd512;
      5'd12: r = 23'sd256;
      5'd13: r = 23'sd128;
      5'd14: r = 23'sd64;
      5'd15: r = 23'sd32;
      5'd16: r = 23'sd16;
      5'd17: r = 23'sd8;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/stz_ctrl.sv
module stz_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          op_i,
  output logic          in_ready_o,
  input  stz_pkg::sts_t sts_i,
  output stz_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_CORD = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;
  logic [stz_pkg::IW-1:0] iter_q, iter_d;
  logic acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    iter_d = iter_q;
    cmd_o = '0;
    cmd_o.accept = acc;
    cmd_o.iter = iter_q;
    case (state_q)
      S_IDLE: begin
        if (acc && op_i == stz_pkg::OP_TICK && sts_i.tick_ok) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.ld_dpsi = 1'b1;
        state_d = S_WRAP;
      end
      S_WRAP: begin
        if (sts_i.dpsi_ok) begin
          iter_d = '0;
          state_d = S_CORD;
        end else begin
          cmd_o.wrap = 1'b1;
        end
      end
      S_CORD: begin
        cmd_o.step = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == stz_pkg::IW'(stz_pkg::CORDIC_STEPS - 1)) state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q <= '0;
    end else begin
      state_q <= state_d;
      iter_q <= iter_d;
    end
  end

endmodule

FILE: hw/rtl/stz_datapath.sv
module stz_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stz_pkg::cmd_t      cmd_i,
  output stz_pkg::sts_t      sts_o,
  input  logic               op_i,
  input  logic [7:0]         wp_index_i,
  input  logic signed [15:0] wp_heading_i,
  input  logic               list_end_i,
  input  logic signed [15:0] vehicle_yaw_i,
  input  logic signed [15:0] lateral_error_i,
  input  logic signed [15:0] vehicle_speed_i,
  input  logic signed [8:0]  nearest_index_i,
  input  logic               pose_valid_i,
  input  logic               frenet_valid_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] steering_angle_o
);

  localparam int CW = stz_pkg::CW;
  localparam int ZW = stz_pkg::ZW;

  logic signed [15:0] mem [stz_pkg::TBL_DEPTH];
  logic signed [15:0] rd_q;
  logic [15:0] gain_q;
  logic [14:0] minsp_q, rate_q;
  logic [8:0] count_q;
  logic signed [15:0] prev_q;
  logic signed [15:0] yaw_q;
  logic signed [16:0] dpsi_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic zero_q;
  logic signed [15:0] corr_q;
  logic out_valid_q;
  logic signed [15:0] out_q;

  logic ld, tk, wr;
  logic signed [16:0] v;
  logic [16:0] den;
  logic signed [CW-1:0] xs, ys;
  logic [ZW-1:0] mag;
  logic [ZW-1:0] magr;
  logic signed [18:0] ang, diff, rl, sel;

  assign ld = cmd_i.accept && op_i == stz_pkg::OP_LOAD &&
              32'(wp_index_i) < stz_pkg::TBL_DEPTH;
  assign tk = cmd_i.accept && op_i == stz_pkg::OP_TICK;
  assign wr = psel && penable && pwrite;

  assign sts_o.tick_ok = pose_valid_i && frenet_valid_i && count_q != 9'd0 &&
                         !nearest_index_i[8] && {1'b0, nearest_index_i[7:0]} < count_q;
  assign sts_o.dpsi_ok = dpsi_q <= stz_pkg::PI_Q12 && dpsi_q > -stz_pkg::PI_Q12;
  assign sts_o.out_full = out_valid_q && !out_ready_i;

  always_comb begin
    case (paddr[3:2])
      stz_pkg::REG_GAIN: prdata = {16'd0, gain_q};
      stz_pkg::REG_MIN_SPEED: prdata = {17'd0, minsp_q};
      stz_pkg::REG_RATE: prdata = {17'd0, rate_q};
      default: prdata = '0;
    endcase
  end

  assign v = (vehicle_speed_i > $signed({2'b00, minsp_q})) ?
             17'(vehicle_speed_i) : $signed({2'b00, minsp_q});
  assign den = {1'b0, gain_q} + v[16:0];

  assign xs = x_q >>> cmd_i.iter;
  assign ys = y_q >>> cmd_i.iter;

  assign mag = z_q[ZW-1] ? ZW'(-z_q) : z_q;
  assign magr = (mag + ZW'(128)) >> 8;

  assign rl = $signed({4'b0000, rate_q});
  assign ang = 19'(dpsi_q) + 19'(corr_q);
  assign diff = ang - 19'(prev_q);

  always_comb begin
    if (diff > rl) sel = 19'(prev_q) + rl;
    else if (diff < -rl) sel = 19'(prev_q) - rl;
    else sel = ang;
  end

  always_ff @(posedge clk_i) begin
    if (ld) mem[stz_pkg::TBL_AW'(wp_index_i)] <= wp_heading_i;
    if (tk) rd_q <= mem[stz_pkg::TBL_AW'(nearest_index_i[7:0])];
  end

  always_ff @(posedge clk_i) begin
    if (tk) begin
      yaw_q <= vehicle_yaw_i;
      x_q <= $signed({3'b000, den, 10'd0});
      y_q <= $signed({{6{lateral_error_i[15]}}, lateral_error_i, 8'd0});
      z_q <= '0;
      zero_q <= den == 17'd0 && lateral_error_i == 16'sd0;
    end else if (cmd_i.step) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + stz_pkg::atan_lut(cmd_i.iter);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - stz_pkg::atan_lut(cmd_i.iter);
      end
    end
    if (cmd_i.ld_dpsi) dpsi_q <= 17'(yaw_q) - 17'(rd_q);
    else if (cmd_i.wrap) begin
      if (dpsi_q > stz_pkg::PI_Q12) dpsi_q <= dpsi_q - stz_pkg::TWO_PI_Q12;
      else dpsi_q <= dpsi_q + stz_pkg::TWO_PI_Q12;
    end
    if (cmd_i.round) begin
      if (zero_q) corr_q <= '0;
      else if (z_q[ZW-1]) corr_q <= -$signed(magr[15:0]);
      else corr_q <= $signed(magr[15:0]);
    end
    if (cmd_i.finish) begin
      if (sel > 19'sd32767) out_q <= 16'sh7fff;
      else if (sel < -19'sd32768) out_q <= 16'sh8000;
      else out_q <= sel[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd307;
      minsp_q <= 15'd26;
      rate_q <= 15'd246;
      count_q <= '0;
      prev_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr) begin
        case (paddr[3:2])
          stz_pkg::REG_GAIN: gain_q <= pwdata[15:0];
          stz_pkg::REG_MIN_SPEED: minsp_q <= pwdata[14:0];
          stz_pkg::REG_RATE: rate_q <= pwdata[14:0];
          default: ;
        endcase
      end
      if (ld && list_end_i) count_q <= {1'b0, wp_index_i} + 9'd1;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (sel > 19'sd32767) prev_q <= 16'sh7fff;
        else if (sel < -19'sd32768) prev_q <= 16'sh8000;
        else prev_q <= sel[15:0];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign steering_angle_o = out_q;

endmodule

FILE: hw/rtl/stanley_steering_rate_limited.sv
// Stanley steering step with a per-tick rate limit.
// Input channel (in_valid_i/in_ready_o): op 0 loads a waypoint heading into
// the 256-entry table, list_end sets the waypoint count; op 1 is a control
// tick with yaw, lateral error, speed, nearest index and valid flags.
// Output channel (out_valid_o/out_ready_i): one steering angle per valid tick,
// none for loads or for ticks with invalid data or an index out of range.
// From acceptance to out_valid_o a tick passes one table read, up to three
// wrap steps, 18 CORDIC iterations, one rounding and one limit stage.
// Loads and dropped ticks leave the block ready for the next item. One item
// is worked on at a time; the next is taken only once the last is done.
// A finished angle waits in the output register while the next item is taken;
// if the receiver stalls, the following tick holds in its last stage.
// Configuration: APB registers softening_gain (0x0), min_speed (0x4),
// rate_limit (0x8); write them only while idle, the block does not enforce it.
// Reset clears the waypoint count, the previous angle and the output valid,
// and restores register defaults; table contents are undefined until written.
module stanley_steering_rate_limited (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [7:0]         wp_index_i,
  input  logic signed [15:0] wp_heading_i,
  input  logic               list_end_i,
  input  logic signed [15:0] vehicle_yaw_i,
  input  logic signed [15:0] lateral_error_i,
  input  logic signed [15:0] vehicle_speed_i,
  input  logic signed [8:0]  nearest_index_i,
  input  logic               pose_valid_i,
  input  logic               frenet_valid_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] steering_angle_o
);

  stz_pkg::cmd_t cmd;
  stz_pkg::sts_t sts;

  assign pready = 1'b1;

  stz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stz_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .wp_index_i       (wp_index_i),
    .wp_heading_i     (wp_heading_i),
    .list_end_i       (list_end_i),
    .vehicle_yaw_i    (vehicle_yaw_i),
    .lateral_error_i  (lateral_error_i),
    .vehicle_speed_i  (vehicle_speed_i),
    .nearest_index_i  (nearest_index_i),
    .pose_valid_i     (pose_valid_i),
    .frenet_valid_i   (frenet_valid_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .steering_angle_o (steering_angle_o)
  );

endmodule

FILE: hw/rtl/stz_checker.sv
module stz_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               pready,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] steering_angle_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(steering_angle_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too soon after transaction");

endmodule

bind stanley_steering_rate_limited stz_checker u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .pready           (pready),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .steering_angle_o (steering_angle_o)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic              op;
    logic [7:0]        wp_index;
    logic signed [15:0] wp_heading;
    logic              list_end;
    logic signed [15:0] yaw;
    logic signed [15:0] lat;
    logic signed [15:0] spd;
    logic signed [8:0]  near;
    logic              pose_ok;
    logic              frenet_ok;
  } steer_item_t;

  typedef struct {
    steer_item_t item;
    logic        known;
    logic signed [15:0] angle;
  } steer_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [7:0] wp_index_i = '0;
  logic signed [15:0] wp_heading_i = '0;
  logic list_end_i = 1'b0;
  logic signed [15:0] vehicle_yaw_i = '0;
  logic signed [15:0] lateral_error_i = '0;
  logic signed [15:0] vehicle_speed_i = '0;
  logic signed [8:0] nearest_index_i = '0;
  logic pose_valid_i = 1'b0;
  logic frenet_valid_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] steering_angle_o;

  stanley_steering_rate_limited u_dut (.*);

  logic signed [15:0] heading_mem [0:stz_pkg::TBL_DEPTH-1];
  int unsigned wp_count;
  int prev_angle;
  int unsigned gain_q8, min_spd_q8, rate_q12;

  logic signed [15:0] angle_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic int steer_atan2(longint y, longint x);
    longint z, xs, ys, mag;
    longint tab [0:17] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                           8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8};
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < 18; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    mag = z < 0 ? -z : z;
    mag = (mag + 128) >> 8;
    return int'(z < 0 ? -mag : mag);
  endfunction

  // returns 1 when the transaction yields a steering angle
  function automatic bit predict_steer(steer_item_t it, output logic signed [15:0] ang_o);
    int dpsi, v, ang, diff, rl, n;
    longint den;
    ang_o = '0;
    if (it.op == stz_pkg::OP_LOAD) begin
      heading_mem[it.wp_index] = it.wp_heading;
      if (it.list_end) wp_count = it.wp_index + 1;
      return 1'b0;
    end
    n = it.near;
    if (!it.pose_ok || !it.frenet_ok || wp_count == 0) return 1'b0;
    if (n < 0 || n >= wp_count) return 1'b0;
    dpsi = int'(it.yaw) - int'(heading_mem[n]);
    while (dpsi > 12868) dpsi -= 25736;
    while (dpsi <= -12868) dpsi += 25736;
    v = int'(it.spd) > int'(min_spd_q8) ? int'(it.spd) : int'(min_spd_q8);
    den = (longint'(gain_q8) + v) * 4;
    ang = dpsi + steer_atan2(longint'(it.lat) * 256, den * 256);
    rl = rate_q12;
    diff = ang - prev_angle;
    if (diff > rl) ang = prev_angle + rl;
    else if (diff < -rl) ang = prev_angle - rl;
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    prev_angle = ang;
    ang_o = ang[15:0];
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected angle %0d", $time, steering_angle_o);
        errors++;
      end else begin
        if (steering_angle_o !== angle_q[0]) begin
          $display("%0t: angle expected %0d actual %0d", $time, angle_q[0],
                   steering_angle_o);
          errors++;
        end
        void'(angle_q.pop_front());
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (recv_hold) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic apb_write(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      stz_pkg::REG_GAIN: gain_q8 = val & 16'hFFFF;
      stz_pkg::REG_MIN_SPEED: min_spd_q8 = val & 15'h7FFF;
      stz_pkg::REG_RATE: rate_q12 = val & 15'h7FFF;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (angle_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  // send one transaction; the predictor runs at acceptance
  task automatic send_item(steer_item_t it, logic known, logic signed [15:0] want);
    logic signed [15:0] ang;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= it.op; wp_index_i <= it.wp_index; wp_heading_i <= it.wp_heading;
    list_end_i <= it.list_end; vehicle_yaw_i <= it.yaw; lateral_error_i <= it.lat;
    vehicle_speed_i <= it.spd; nearest_index_i <= it.near;
    pose_valid_i <= it.pose_ok; frenet_valid_i <= it.frenet_ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_steer(it, ang)) begin
      if (known && ang !== want) begin
        $display("%0t: directed row expected %0d model gives %0d", $time, want, ang);
        errors++;
      end
      angle_q = {angle_q, ang};
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic steer_item_t load_item(int idx, int hd, bit last);
    steer_item_t it;
    it = '{default: '0};
    it.op = stz_pkg::OP_LOAD; it.wp_index = idx; it.wp_heading = hd; it.list_end = last;
    return it;
  endfunction

  function automatic steer_item_t tick_item(int yaw, int lat, int spd, int near,
                                            bit p, bit f);
    steer_item_t it;
    it = '{default: '0};
    it.op = stz_pkg::OP_TICK; it.yaw = yaw; it.lat = lat; it.spd = spd; it.near = near;
    it.pose_ok = p; it.frenet_ok = f;
    it.wp_index = $urandom; it.wp_heading = $urandom; it.list_end = $urandom;
    return it;
  endfunction

  function automatic steer_item_t random_item(int unsigned n_wp);
    steer_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < 12) begin
      it = load_item($urandom_range(n_wp - 1), $urandom, 1'b0);
      it.list_end = ($urandom_range(9) == 0);
      if (it.list_end) it.wp_index = n_wp - 1;
    end else if (r < 88) begin
      it = tick_item($urandom, $urandom, $urandom, $urandom_range(n_wp - 1), 1, 1);
      if ($urandom_range(3) == 0) it.spd = $urandom_range(3000);
      if ($urandom_range(3) == 0) it.lat = $signed(16'($urandom_range(64))) - 32;
    end else begin
      it = tick_item($urandom, $urandom, $urandom, $urandom_range(511),
                     $urandom, $urandom);
      if (it.near >= 0 && it.near < n_wp) it.pose_ok = 1'b0;
    end
    if (it.op == stz_pkg::OP_LOAD) begin
      it.yaw = $urandom; it.lat = $urandom; it.spd = $urandom;
      it.near = $urandom; it.pose_ok = $urandom; it.frenet_ok = $urandom;
    end
    return it;
  endfunction

  task automatic fill_table(int unsigned n_wp);
    for (int i = 0; i < n_wp; i++)
      send_item(load_item(i, $urandom, i == n_wp - 1), 1'b0, '0);
  endtask

  task automatic run_random(int count, int unsigned n_wp);
    for (int i = 0; i < count; i++) send_item(random_item(n_wp), 1'b0, '0);
  endtask

  steer_row_t dir_rows[$];

  task automatic add_row(steer_item_t it, logic known, logic signed [15:0] want);
    steer_row_t row;
    row.item = it;
    row.known = known;
    row.angle = want;
    dir_rows = {dir_rows, row};
  endtask

  initial begin
    int unsigned nwp;
    gain_q8 = 307; min_spd_q8 = 26; rate_q12 = 246;
    wp_count = 0; prev_angle = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset registers first
    add_row(tick_item(0, 0, 0, 0, 1, 1), 1'b0, '0);
    add_row(load_item(0, 0, 1'b0), 1'b0, '0);
    add_row(tick_item(0, 0, 0, 0, 1, 1), 1'b0, '0);
    add_row(load_item(1, 32767, 1'b0), 1'b0, '0);
    add_row(load_item(2, -32768, 1'b1), 1'b0, '0);
    add_row(load_item(255, 100, 1'b0), 1'b0, '0);
    add_row(tick_item(0, 0, 0, 0, 1, 1), 1'b1, 16'sd0);
    add_row(tick_item(0, 0, 0, 0, 0, 1), 1'b0, '0);
    add_row(tick_item(0, 0, 0, 0, 1, 0), 1'b0, '0);
    add_row(tick_item(0, 0, 0, -1, 1, 1), 1'b0, '0);
    add_row(tick_item(0, 0, 0, 3, 1, 1), 1'b0, '0);
    add_row(tick_item(0, 0, 0, 255, 1, 1), 1'b0, '0);
    add_row(tick_item(32767, 32767, -32768, 0, 1, 1), 1'b1, 16'sd246);
    add_row(tick_item(-32768, -32768, 32767, 1, 1, 1), 1'b0, '0);
    add_row(tick_item(32767, 0, 0, 2, 1, 1), 1'b0, '0);
    add_row(tick_item(-32768, 100, 500, 1, 1, 1), 1'b0, '0);
    add_row(tick_item(12868, -5, 0, 0, 1, 1), 1'b0, '0);
    add_row(tick_item(-12868, 5, 0, 0, 1, 1), 1'b0, '0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].angle);
    drain_results();

    // zero denominator and wide rate limit
    apb_write(stz_pkg::REG_GAIN, 0);
    apb_write(stz_pkg::REG_MIN_SPEED, 0);
    apb_write(stz_pkg::REG_RATE, 32767);
    send_item(tick_item(0, 0, 0, 0, 1, 1), 1'b1, 16'sd0);
    send_item(tick_item(0, 5, -100, 0, 1, 1), 1'b0, '0);
    send_item(tick_item(32767, 32767, 0, 1, 1, 1), 1'b0, '0);
    send_item(tick_item(-32768, -32768, 0, 2, 1, 1), 1'b0, '0);
    drain_results();
    apb_write(stz_pkg::REG_GAIN, 65535);
    apb_write(stz_pkg::REG_MIN_SPEED, 32767);
    apb_write(stz_pkg::REG_RATE, 0);
    send_item(tick_item(1000, 32767, 32767, 0, 1, 1), 1'b0, '0);
    drain_results();

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 8 : 0;
      for (int k = 0; k < 2; k++) begin
        apb_write(stz_pkg::REG_GAIN,
                  (k == 0) ? $urandom_range(65535) : $urandom_range(600));
        apb_write(stz_pkg::REG_MIN_SPEED,
                  (k == 0) ? $urandom_range(32767) : $urandom_range(100));
        apb_write(stz_pkg::REG_RATE,
                  (k == 0) ? $urandom_range(32767) : $urandom_range(400));
        nwp = (k == 0) ? $urandom_range(2, 16) : $urandom_range(200, 256);
        fill_table(nwp);
        run_random((k == 0) ? 100 : 30, nwp);
        drain_results();
      end
    end

    // hold off the receiver so the block fills up and stalls its input
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      run_random(20, nwp);
    join
    drain_results();
    run_random(100, nwp);
    drain_results();

    if (angle_q.size() != 0) begin
      $display("%0t: %0d angles expected actual none", $time, angle_q.size());
      errors++;
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
